FILE: sv/lps_pkg.sv
// Shared types for the linear prime sieve: controller states, result kinds,
// and the command and status groups between controller and datapath.
// No dependencies.
package lps_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READF,
      ST_LOOP_RD,
      ST_LOOP_MUL,
      ST_LOOP_WR
   } state_type;

   // What goes into the output register
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_DONE,
      RES_NUM
   } res_kind_type;

   // Controller -> datapath
   typedef struct packed {
      logic         restart_state;  // n back to 2, count to 0, sweep from 0
      logic         resolve;        // settle factor of n, append prime
      logic         capture_mul;    // register prime and product
      logic         mark;           // write factor of product, next prime
      logic         clear_step;     // one entry of the clearing pass
      logic         out_load;       // load the output register
      res_kind_type out_kind;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic over_lim;    // next number is above the active limit
      logic list_end;    // prime index reached the prime count
      logic mark_break;  // prime above factor or product above limit
      logic clear_last;  // clearing pass at its last entry
      logic out_busy;    // output register holds a stalled result
   } status_type;

endpackage

FILE: sv/lps_ctrl.sv
// Sequencing controller of the linear prime sieve.
// Depends on lps_pkg; drives commands to lps_dpath and the input stall.
module lps_ctrl
   import lps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_restart,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.out_kind = RES_NUM;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = status.out_busy;
            if (req_valid && !status.out_busy) begin
               if (req_restart) begin
                  cmd.out_load      = 1'b1;
                  cmd.out_kind      = RES_ZERO;
                  cmd.restart_state = 1'b1;
                  state_in          = ST_CLEAR;
               end else if (status.over_lim) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = RES_DONE;
               end else begin
                  state_in = ST_READF;
               end
            end
         end
         ST_READF: begin
            cmd.resolve = 1'b1;
            state_in    = ST_LOOP_RD;
         end
         ST_LOOP_RD: begin
            // prime read is issued here when the list goes on
            if (status.list_end) begin
               if (!status.out_busy) begin
                  cmd.out_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_LOOP_MUL;
            end
         end
         ST_LOOP_MUL: begin
            cmd.capture_mul = 1'b1;
            state_in        = ST_LOOP_WR;
         end
         ST_LOOP_WR: begin
            if (status.mark_break) begin
               if (!status.out_busy) begin
                  cmd.out_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.mark = 1'b1;
               state_in = ST_LOOP_RD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: sv/lps_dpath.sv
// Datapath of the linear prime sieve: factor store, prime list, multiplier,
// sieve registers, limit register and output register.
// Depends on lps_pkg; commanded by lps_ctrl.
module lps_dpath
   import lps_pkg::*;
#(
   parameter int unsigned MAX_NUMBER  = 65535,
   parameter int unsigned PRIME_SLOTS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_valid,
   input  logic [15:0] csr_data,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [15:0] rsp_number,
   output logic [15:0] rsp_least_factor,
   output logic        rsp_is_prime,
   output logic [13:0] rsp_prime_count,
   output logic        rsp_done_res
);

   localparam int unsigned AW      = $clog2(MAX_NUMBER + 1);
   localparam int unsigned NW      = AW + 1;
   localparam int unsigned PW      = $clog2(PRIME_SLOTS);
   localparam int unsigned CW      = (NW > 17) ? NW : 17;
   localparam int unsigned PRW     = NW + 16;
   localparam int unsigned MAX_CAP = (MAX_NUMBER < 65535) ? MAX_NUMBER : 65535;

   // Memories
   logic [15:0] fstore_mem [0:MAX_NUMBER];
   logic [15:0] plist_mem  [0:PRIME_SLOTS-1];
   logic [15:0] fstore_rd_ff;
   logic [15:0] plist_rd_ff;

   // Sieve registers
   logic [NW-1:0]  n_ff;
   logic [PW:0]    count_ff;
   logic [PW:0]    j_ff;
   logic [AW-1:0]  clr_ff;
   logic [15:0]    limit_ff;
   logic [15:0]    f_ff;
   logic           prime_ff;
   logic [15:0]    p_ff;
   logic [PRW-1:0] prod_ff;
   logic [PRW-1:0] prod_in;

   // Output register
   logic        rsp_valid_ff;
   logic [15:0] number_ff;
   logic [15:0] lf_ff;
   logic        is_prime_ff;
   logic [13:0] pcount_ff;
   logic        done_ff;

   logic [15:0]   lim;
   logic          fstore_we;
   logic [AW-1:0] fstore_wa;
   logic [15:0]   fstore_wd;
   logic          plist_we;
   logic          f_zero;

   // Active limit is the register capped at the largest storable number
   assign lim    = (limit_ff < 16'(MAX_CAP)) ? limit_ff : 16'(MAX_CAP);
   assign f_zero = (fstore_rd_ff == 16'd0);

   assign prod_in = PRW'(n_ff) * PRW'(plist_rd_ff);

   // Status
   assign status.over_lim   = CW'(n_ff) > CW'(lim);
   assign status.list_end   = (j_ff >= count_ff);
   assign status.mark_break = (p_ff > f_ff) || (prod_ff > PRW'(lim));
   assign status.clear_last = (clr_ff == AW'(MAX_NUMBER));
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   // Factor store write select: clearing pass, new prime, or marking
   always_comb begin
      fstore_we = 1'b0;
      fstore_wa = clr_ff;
      fstore_wd = 16'd0;
      if (cmd.clear_step) begin
         fstore_we = 1'b1;
      end else if (cmd.resolve && f_zero) begin
         fstore_we = 1'b1;
         fstore_wa = n_ff[AW-1:0];
         fstore_wd = 16'(n_ff);
      end else if (cmd.mark) begin
         fstore_we = 1'b1;
         fstore_wa = prod_ff[AW-1:0];
         fstore_wd = p_ff;
      end
   end

   assign plist_we = cmd.resolve && f_zero && (count_ff < (PW + 1)'(PRIME_SLOTS));

   // Factor store: always read at the current number
   always_ff @(posedge clock) begin
      if (fstore_we) begin
         fstore_mem[fstore_wa] <= fstore_wd;
      end
      fstore_rd_ff <= fstore_mem[n_ff[AW-1:0]];
   end

   // Prime list: written at the count, read at the loop index
   always_ff @(posedge clock) begin
      if (plist_we) begin
         plist_mem[count_ff[PW-1:0]] <= 16'(n_ff);
      end
      plist_rd_ff <= plist_mem[j_ff[PW-1:0]];
   end

   // Control registers of the sieve
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= NW'(2);
         count_ff <= '0;
         clr_ff   <= '0;
         limit_ff <= 16'hFFFF;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.restart_state) begin
            n_ff     <= NW'(2);
            count_ff <= '0;
            clr_ff   <= '0;
         end else begin
            if (cmd.clear_step) begin
               clr_ff <= clr_ff + AW'(1);
            end
            if (plist_we) begin
               count_ff <= count_ff + (PW + 1)'(1);
            end
            if (cmd.out_load && cmd.out_kind == RES_NUM) begin
               n_ff <= n_ff + NW'(1);
            end
         end
      end
   end

   // Per-number working registers
   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         j_ff     <= '0;
         prime_ff <= f_zero;
         f_ff     <= f_zero ? 16'(n_ff) : fstore_rd_ff;
      end else if (cmd.mark) begin
         j_ff <= j_ff + (PW + 1)'(1);
      end
      if (cmd.capture_mul) begin
         p_ff    <= plist_rd_ff;
         prod_ff <= prod_in;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_kind)
            RES_ZERO: begin
               number_ff   <= 16'd0;
               lf_ff       <= 16'd0;
               is_prime_ff <= 1'b0;
               pcount_ff   <= 14'd0;
               done_ff     <= 1'b0;
            end
            RES_DONE: begin
               number_ff   <= 16'd0;
               lf_ff       <= 16'd0;
               is_prime_ff <= 1'b0;
               pcount_ff   <= 14'(count_ff);
               done_ff     <= 1'b1;
            end
            default: begin
               number_ff   <= 16'(n_ff);
               lf_ff       <= f_ff;
               is_prime_ff <= prime_ff;
               pcount_ff   <= 14'(count_ff);
               done_ff     <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_number       = number_ff;
   assign rsp_least_factor = lf_ff;
   assign rsp_is_prime     = is_prime_ff;
   assign rsp_prime_count  = pcount_ff;
   assign rsp_done_res     = done_ff;

endmodule

FILE: sv/linear_prime_sieve_unit.sv
// Top level of the linear prime sieve unit.
// Depends on lps_pkg, lps_ctrl and lps_dpath.
//
// Each advance item sieves the next number from 2 upward and returns it with
// its least prime factor, a prime flag and the running prime count; past the
// limit it returns done and changes nothing. After its transfer an advance
// item reads and settles its factor. The marking loop then passes through a
// prime list read, a multiply and a factor store write for each listed prime
// it visits, including the prime that stops the loop. When the list runs out
// first, the loop ends on a last list check. The result is loaded at the end
// of the loop, and the unit then returns to idle for the next item. Each
// further prime at or below the least factor adds another pass through the
// loop, and a product past the limit cuts the loop short. A done item is
// answered from the idle state, which stays ready for the next item. After
// reset and after every restart item, a clearing pass writes zero to all
// MAX_NUMBER+1 factor store entries, one per cycle, and no item is taken
// during the pass. Limit writes are always accepted (csr_ready is always
// high). Results sit in an output register. While a stalled receiver holds
// a result there, no new item is taken, and a finished item waits in the
// controller until the register is free.
module linear_prime_sieve_unit
   import lps_pkg::*;
#(
   parameter int unsigned MAX_NUMBER  = 65535,
   parameter int unsigned PRIME_SLOTS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_number,
   output logic [15:0] rsp_least_factor,
   output logic        rsp_is_prime,
   output logic [13:0] rsp_prime_count,
   output logic        rsp_done_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Sequencer
   lps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Storage and arithmetic
   lps_dpath #(
      .MAX_NUMBER  (MAX_NUMBER),
      .PRIME_SLOTS (PRIME_SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_number       (rsp_number),
      .rsp_least_factor (rsp_least_factor),
      .rsp_is_prime     (rsp_is_prime),
      .rsp_prime_count  (rsp_prime_count),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

FILE: sv/lps_checker.sv
// Port-level checks for the linear prime sieve unit, bound to the top level.
// Depends only on the top level's ports.
module lps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_restart,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_number,
   input logic [15:0] rsp_least_factor,
   input logic        rsp_is_prime,
   input logic [13:0] rsp_prime_count,
   input logic        rsp_done_res
);

   // A stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_number) &&
         $stable(rsp_least_factor) && $stable(rsp_is_prime) &&
         $stable(rsp_prime_count) && $stable(rsp_done_res))
      else $error("stalled result changed");

   // A prime is its own least factor
   a_prime_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_least_factor == rsp_number &&
         rsp_number != 16'd0 && !rsp_done_res)
      else $error("prime result with wrong factor");

   // A sieved number has a nonzero factor not above itself
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res && rsp_number != 16'd0 |->
         rsp_least_factor != 16'd0 && rsp_least_factor <= rsp_number)
      else $error("least factor out of range");

   // A restart transfer starts the clearing pass, so no transfer follows at once
   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_restart |=> req_stall)
      else $error("item taken during clearing pass");

endmodule

bind linear_prime_sieve_unit lps_checker u_lps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_restart      (req_restart),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_number       (rsp_number),
   .rsp_least_factor (rsp_least_factor),
   .rsp_is_prime     (rsp_is_prime),
   .rsp_prime_count  (rsp_prime_count),
   .rsp_done_res     (rsp_done_res)
);

FILE: bench/tb.sv
// Self-checking bench for linear_prime_sieve_unit: directed rows, then random
// sieve phases under changing limits, with idles and stalls on both channels.
// Depends only on the RTL of the unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_NUMBER      = 65535;
   localparam int unsigned PRIME_SLOTS     = 8192;
   localparam int          RANDOM_ITEMS    = 1150;
   localparam int          MAX_RESTARTS    = 5;
   localparam int          SETTLE_CYCLES   = 200;
   localparam int          TAIL_CYCLES     = 200;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          CYCLE_LIMIT     = 3000000;
   localparam int          MAX_REPORTS     = 40;

   // One result transfer
   typedef struct packed {
      bit [15:0] number;
      bit [15:0] least_factor;
      bit        is_prime;
      bit [13:0] prime_count;
      bit        done_res;
   } sieve_result_type;

   // Directed stimulus rows
   typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_type;
   typedef struct {
      row_kind_type     kind;
      bit               restart;
      bit               known;
      sieve_result_type want;
      bit [15:0]        limit_value;
   } directed_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_restart = 1'b0;
   logic        rsp_stall  = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [15:0] csr_data   = 16'd0;
   logic        req_stall;
   logic        rsp_valid;
   logic [15:0] rsp_number;
   logic [15:0] rsp_least_factor;
   logic        rsp_is_prime;
   logic [13:0] rsp_prime_count;
   logic        rsp_done_res;
   logic        csr_ready;

   // Predictor state: least factor per number, prime list, sieve position
   bit [15:0]   factor_of [0:MAX_NUMBER];
   bit [15:0]   primes_listed [0:PRIME_SLOTS-1];
   bit [16:0]   sieve_next  = 17'd2;
   int unsigned prime_total = 0;
   bit [15:0]   limit_reg   = 16'hFFFF;

   sieve_result_type expected_q [$];
   directed_row_type directed_rows [$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  items_sent = 0;
   int  restarts_sent = 0;
   int  done_seen = 0;
   int  primes_seen = 0;
   int  top_number = 0;
   int  limit_writes = 0;
   int  hold_offs = 0;
   int  cycle_count = 0;
   bit  no_gap_phase = 1'b0;
   bit  hold_off_req = 1'b0;

   linear_prime_sieve_unit #(
      .MAX_NUMBER (MAX_NUMBER),
      .PRIME_SLOTS(PRIME_SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_number      (rsp_number),
      .rsp_least_factor(rsp_least_factor),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_count (rsp_prime_count),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sieve one item: restart clears, past the limit reports done,
   // otherwise settle the factor of the next number and mark its multiples
   function automatic sieve_result_type sieve_one_item(bit restart);
      sieve_result_type r;
      int unsigned      n;
      int unsigned      f;
      int unsigned      p;
      int unsigned      lim;
      int unsigned      j;
      longint unsigned  prod;
      bit               found;
      r = '0;
      found = 1'b0;
      lim = 32'(limit_reg);
      if (lim > MAX_NUMBER) lim = MAX_NUMBER;
      if (restart) begin
         foreach (factor_of[k]) factor_of[k] = 16'd0;
         sieve_next = 17'd2;
         prime_total = 0;
         return r;
      end
      n = 32'(sieve_next);
      if (n > lim) begin
         r.prime_count = prime_total[13:0];
         r.done_res = 1'b1;
         return r;
      end
      f = 32'(factor_of[n]);
      if (f == 0) begin
         f = n;
         factor_of[n] = n[15:0];
         found = 1'b1;
         if (prime_total < PRIME_SLOTS) begin
            primes_listed[prime_total] = n[15:0];
            prime_total++;
         end
      end
      // each composite gets marked once, by its least prime
      for (j = 0; j < prime_total; j++) begin
         p = 32'(primes_listed[j]);
         prod = longint'(n) * longint'(p);
         if (p > f || prod > lim) break;
         factor_of[prod[15:0]] = p[15:0];
      end
      sieve_next = 17'(n + 1);
      r.number = n[15:0];
      r.least_factor = f[15:0];
      r.is_prime = found;
      r.prime_count = prime_total[13:0];
      return r;
   endfunction

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gap_phase || pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic add_item_row(bit restart);
      directed_row_type row;
      row.kind = ROW_ITEM;
      row.restart = restart;
      row.known = 1'b0;
      row.want = '0;
      row.limit_value = 16'd0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_known_row(bit restart, int number, int least_factor, bit is_prime,
                                int prime_count, bit done_res);
      directed_row_type row;
      row.kind = ROW_ITEM;
      row.restart = restart;
      row.known = 1'b1;
      row.want.number = number[15:0];
      row.want.least_factor = least_factor[15:0];
      row.want.is_prime = is_prime;
      row.want.prime_count = prime_count[13:0];
      row.want.done_res = done_res;
      row.limit_value = 16'd0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_limit_row(bit [15:0] value);
      directed_row_type row;
      row.kind = ROW_LIMIT;
      row.restart = 1'b0;
      row.known = 1'b0;
      row.want = '0;
      row.limit_value = value;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one item after an optional idle gap; predict it on transfer
   task automatic send_item(bit restart, bit known, sieve_result_type want);
      int               gap;
      sieve_result_type predicted;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = sieve_one_item(restart);
      expected_q.insert(expected_q.size(), known ? want : predicted);
      items_sent++;
      if (restart) restarts_sent++;
      if (predicted.done_res) done_seen++;
      if (predicted.is_prime) primes_seen++;
      if (int'(predicted.number) > top_number) top_number = int'(predicted.number);
   endtask

   // Stop offering and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   // Limit write, only with the unit idle
   task automatic write_limit(bit [15:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                  results_checked, what, got, want);
      mismatch_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      sieve_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_q.size() == 0) begin
            report_mismatch("transfer with nothing pending, number", 32'(rsp_number), 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_number !== want.number)
               report_mismatch("number", 32'(rsp_number), 32'(want.number));
            if (rsp_least_factor !== want.least_factor)
               report_mismatch("least_factor", 32'(rsp_least_factor),
                               32'(want.least_factor));
            if (rsp_is_prime !== want.is_prime)
               report_mismatch("is_prime", 32'(rsp_is_prime), 32'(want.is_prime));
            if (rsp_prime_count !== want.prime_count)
               report_mismatch("prime_count", 32'(rsp_prime_count),
                               32'(want.prime_count));
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", 32'(rsp_done_res), 32'(want.done_res));
         end
         results_checked++;
      end
   end

   // Receiver stalls: short and long stalls, free stretches, requested hold-offs
   initial begin
      int pick;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_offs++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(40, 150)) @(posedge clock);
            end else if (pick < 15) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else if (pick < 55) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_q.size());
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus
   initial begin
      int               phase;
      int               random_sent;
      int               n_items;
      int               fresh_restarts;
      int               cand;
      bit               fresh;
      bit [15:0]        new_limit;
      sieve_result_type none;

      none = '0;
      phase = 0;
      random_sent = 0;
      fresh_restarts = 0;

      // First numbers at the reset limit, then restart
      add_known_row(1'b0, 2, 2, 1'b1, 1, 1'b0);
      add_known_row(1'b0, 3, 3, 1'b1, 2, 1'b0);
      add_known_row(1'b0, 4, 2, 1'b0, 2, 1'b0);
      add_known_row(1'b0, 5, 5, 1'b1, 3, 1'b0);
      add_known_row(1'b0, 6, 2, 1'b0, 3, 1'b0);
      add_known_row(1'b1, 0, 0, 1'b0, 0, 1'b0);
      add_known_row(1'b0, 2, 2, 1'b1, 1, 1'b0);
      // Limit below two: everything is done
      add_limit_row(16'd0);
      add_known_row(1'b0, 0, 0, 1'b0, 1, 1'b1);
      add_limit_row(16'd1);
      add_known_row(1'b0, 0, 0, 1'b0, 1, 1'b1);
      add_known_row(1'b1, 0, 0, 1'b0, 0, 1'b0);
      add_known_row(1'b0, 0, 0, 1'b0, 0, 1'b1);
      // Smallest useful limit, then raised: 4 was never marked
      add_limit_row(16'd2);
      add_known_row(1'b0, 2, 2, 1'b1, 1, 1'b0);
      add_known_row(1'b0, 0, 0, 1'b0, 1, 1'b1);
      add_limit_row(16'hFFFF);
      add_known_row(1'b0, 3, 3, 1'b1, 2, 1'b0);
      repeat (3) add_item_row(1'b0);
      // Run up to a small limit and past it
      add_limit_row(16'd10);
      repeat (5) add_item_row(1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_LIMIT)
            write_limit(directed_rows[k].limit_value);
         else
            send_item(directed_rows[k].restart, directed_rows[k].known,
                      directed_rows[k].want);
      end

      // Random phases: fresh sieves after a restart, or a limit change mid-sieve
      while (random_sent < RANDOM_ITEMS) begin
         fresh = (phase % 2 == 0) && (fresh_restarts < MAX_RESTARTS);
         if (fresh) begin
            new_limit = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(2, 400));
         end else begin
            case ($urandom_range(0, 3))
               0: new_limit = 16'hFFFF;
               1: new_limit = 16'($urandom_range(0, 65535));
               default: begin
                  cand = int'(sieve_next) + int'($urandom_range(0, 120)) - 40;
                  if (cand < 0) cand = 0;
                  if (cand > 65535) cand = 65535;
                  new_limit = cand[15:0];
               end
            endcase
         end
         write_limit(new_limit);
         no_gap_phase = ($urandom_range(0, 3) == 0);
         n_items = $urandom_range(60, 140);
         if (fresh) begin
            send_item(1'b1, 1'b0, none);
            fresh_restarts++;
            random_sent++;
         end
         for (int i = 0; i < n_items && random_sent < RANDOM_ITEMS; i++) begin
            // long receiver hold-off while items keep coming
            if (i == 10 && (phase == 2 || phase == 6)) hold_off_req = 1'b1;
            send_item(1'b0, 1'b0, none);
            random_sent++;
         end
         phase++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items (%0d restarts, %0d past the limit), %0d primes, up to %0d.",
               items_sent, restarts_sent, done_seen, primes_seen, top_number);
      $display("%0d limit settings, %0d receiver hold-offs, %0d results checked in %0d cycles.",
               limit_writes, hold_offs, results_checked, cycle_count);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
